// ===== rtl/core/bbo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box overlay package
// Shared types, constants and the class colour palette for the overlay core.
// ----------------------------------------------------------------------------
package bbo_pkg;

	// Sizes and defaults.
	localparam int MAX_BOXES_DEF = 16;
	localparam int CMD_DEPTH     = 4;
	localparam int RES_DEPTH     = 2;
	localparam int NUM_COLOURS   = 21;
	localparam int DIM_W         = 13;
	localparam int POS_W         = 12;
	localparam int THICK_W       = 8;
	localparam int COLOUR_W      = 5;
	localparam int CLASS_W       = 10;
	localparam int CH_W          = 8;

	localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
	localparam logic [THICK_W-1:0] THICK_RST  = 8'd2;
	localparam logic [DIM_W-1:0]   DIM_MAX    = 13'd4096;

	// Reciprocal of 21 scaled by 2^16; exact quotient for every 10-bit class.
	localparam logic [11:0] RECIP_21 = 12'd3121;

	// Input action codes.
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_PIXEL = 2'd2
	} action_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_THICK  = 2'd2
	} cfg_index_t;

	// Command kinds passed from the front to the back.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_PIXEL = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic signed [15:0] box_w;
		logic signed [15:0] box_h;
		logic [CLASS_W-1:0] box_class;
		logic [CH_W-1:0]    pixel_c0;
		logic [CH_W-1:0]    pixel_c1;
		logic [CH_W-1:0]    pixel_c2;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_c0;
		logic [CH_W-1:0] out_c1;
		logic [CH_W-1:0] out_c2;
		logic            painted;
		logic            frame_end;
	} result_t;

	// One loaded box, already clipped, with its far edges precomputed.
	typedef struct packed {
		logic [POS_W-1:0]    left;
		logic [POS_W-1:0]    top;
		logic [POS_W-1:0]    right;
		logic [POS_W-1:0]    bottom;
		logic [THICK_W-1:0]  thick;
		logic [COLOUR_W-1:0] colour;
	} box_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [CH_W-1:0]  c0;
		logic [CH_W-1:0]  c1;
		logic [CH_W-1:0]  c2;
		logic             frame_end;
	} pix_t;

	typedef struct packed {
		cmd_kind_t kind;
		box_t      box;
		pix_t      pix;
	} cmd_t;

	typedef struct packed {
		logic [CH_W-1:0] c0;
		logic [CH_W-1:0] c1;
		logic [CH_W-1:0] c2;
	} rgb_t;

	// Class colour palette.
	function automatic rgb_t palette_lookup(input logic [COLOUR_W-1:0] idx);
		rgb_t c;
		case (idx)
			5'd0:    c = '{8'd128, 8'd64,  8'd128};
			5'd1:    c = '{8'd232, 8'd35,  8'd244};
			5'd2:    c = '{8'd70,  8'd70,  8'd70};
			5'd3:    c = '{8'd156, 8'd102, 8'd102};
			5'd4:    c = '{8'd153, 8'd153, 8'd190};
			5'd5:    c = '{8'd153, 8'd153, 8'd153};
			5'd6:    c = '{8'd30,  8'd170, 8'd250};
			5'd7:    c = '{8'd0,   8'd220, 8'd220};
			5'd8:    c = '{8'd35,  8'd142, 8'd107};
			5'd9:    c = '{8'd152, 8'd251, 8'd152};
			5'd10:   c = '{8'd180, 8'd130, 8'd70};
			5'd11:   c = '{8'd60,  8'd20,  8'd220};
			5'd12:   c = '{8'd0,   8'd0,   8'd255};
			5'd13:   c = '{8'd142, 8'd0,   8'd0};
			5'd14:   c = '{8'd70,  8'd0,   8'd0};
			5'd15:   c = '{8'd100, 8'd60,  8'd0};
			5'd16:   c = '{8'd90,  8'd0,   8'd0};
			5'd17:   c = '{8'd230, 8'd0,   8'd0};
			5'd18:   c = '{8'd32,  8'd11,  8'd119};
			5'd19:   c = '{8'd0,   8'd74,  8'd111};
			5'd20:   c = '{8'd81,  8'd0,   8'd81};
			default: c = '{8'd128, 8'd64,  8'd128};
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/bbo_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box overlay word queue
// Small synchronous FIFO used between the front and back and on the output.
// ----------------------------------------------------------------------------
module bbo_fifo #(
	parameter int  DEPTH = bbo_pkg::CMD_DEPTH,
	parameter type T     = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	output logic full,
	input  logic rd_en,
	output T     rd_data,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/bbo_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box overlay front end
// Holds the configuration, clips boxes on load, tracks the raster position
// and hands decoded commands to the back end.
// ----------------------------------------------------------------------------
module bbo_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  bbo_pkg::item_t                item,
	output logic                          full,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [bbo_pkg::DIM_W-1:0]     cfg_data,
	output logic                          cmd_push,
	output bbo_pkg::cmd_t                 cmd,
	input  logic                          cmd_full
);
	import bbo_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [THICK_W-1:0] thick_q;
	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;

	logic               accept;
	logic [DIM_W-1:0]   wd;
	logic [DIM_W-1:0]   ht;
	logic [DIM_W-1:0]   wd_m1;
	logic [DIM_W-1:0]   ht_m1;
	logic [14:0]        xc, yc, wc, hc;
	logic               x_past, y_past;
	logic [POS_W-1:0]   left, top, span_x, span_y;
	logic [POS_W-1:0]   half_x, half_y;
	logic [THICK_W-1:0] th0, th1, th;
	logic [21:0]        class_prod;
	logic [5:0]         class_quot;
	logic [CLASS_W-1:0] class_rem;
	logic               last_col, last_row;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;
	assign accept    = push && !cmd_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thick_q  <= THICK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_THICK:  thick_q  <= cfg_data[THICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, anything above the maximum saturates.
	always_comb begin
		priority if (width_q == '0) wd = DIM_W'(1);
		else if (width_q > DIM_MAX) wd = DIM_MAX;
		else wd = width_q;
		priority if (height_q == '0) ht = DIM_W'(1);
		else if (height_q > DIM_MAX) ht = DIM_MAX;
		else ht = height_q;
	end
	assign wd_m1 = wd - 1'b1;
	assign ht_m1 = ht - 1'b1;

	// Box clipping against the frame.
	always_comb begin
		xc = item.box_x[15] ? '0 : item.box_x[14:0];
		yc = item.box_y[15] ? '0 : item.box_y[14:0];
		wc = item.box_w[15] ? '0 : item.box_w[14:0];
		hc = item.box_h[15] ? '0 : item.box_h[14:0];
		x_past = (xc >= 15'(wd));
		y_past = (yc >= 15'(ht));

		if (x_past) begin
			left   = wd_m1[POS_W-1:0];
			span_x = '0;
		end else begin
			left = xc[POS_W-1:0];
			if ((16'(xc) + 16'(wc)) >= 16'(wd)) span_x = wd_m1[POS_W-1:0] - xc[POS_W-1:0];
			else span_x = wc[POS_W-1:0];
		end

		if (y_past) begin
			top    = ht_m1[POS_W-1:0];
			span_y = '0;
		end else begin
			top = yc[POS_W-1:0];
			if ((16'(yc) + 16'(hc)) >= 16'(ht)) span_y = ht_m1[POS_W-1:0] - yc[POS_W-1:0];
			else span_y = hc[POS_W-1:0];
		end

		// Thickness is capped at half of each span plus one.
		th0    = (x_past || y_past) ? THICK_W'(1) : thick_q;
		half_x = {1'b0, span_x[POS_W-1:1]} + 1'b1;
		half_y = {1'b0, span_y[POS_W-1:1]} + 1'b1;
		th1    = (POS_W'(th0) > half_x) ? half_x[THICK_W-1:0] : th0;
		th     = (POS_W'(th1) > half_y) ? half_y[THICK_W-1:0] : th1;
	end

	// Class modulo 21 through a reciprocal multiply and one correction-free subtract.
	assign class_prod = 22'(item.box_class) * 22'(RECIP_21);
	assign class_quot = class_prod[21:16];
	assign class_rem  = item.box_class - (CLASS_W'(class_quot) * CLASS_W'(NUM_COLOURS));

	// Raster position bookkeeping.
	assign last_col = (col_q >= wd_m1[POS_W-1:0]);
	assign last_row = (row_q >= ht_m1[POS_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (item.action == ACT_CLEAR) begin
				col_q <= '0;
				row_q <= '0;
			end else if (item.action == ACT_PIXEL) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Command word for the back end.
	always_comb begin
		cmd.box.left      = left;
		cmd.box.top       = top;
		cmd.box.right     = left + span_x;
		cmd.box.bottom    = top + span_y;
		cmd.box.thick     = th;
		cmd.box.colour    = class_rem[COLOUR_W-1:0];
		cmd.pix.col       = col_q;
		cmd.pix.row       = row_q;
		cmd.pix.c0        = item.pixel_c0;
		cmd.pix.c1        = item.pixel_c1;
		cmd.pix.c2        = item.pixel_c2;
		cmd.pix.frame_end = last_col && last_row;
		cmd_push          = accept;
		unique case (item.action)
			ACT_CLEAR: cmd.kind = CMD_CLEAR;
			ACT_ADD:   cmd.kind = CMD_ADD;
			ACT_PIXEL: cmd.kind = CMD_PIXEL;
			default: begin
				cmd.kind = CMD_CLEAR;
				cmd_push = 1'b0;
			end
		endcase
	end

	// A restart puts the raster position back at the origin.
	a_clear_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.action == ACT_CLEAR |=> col_q == '0 && row_q == '0)
		else $error("raster position not restarted after clear");

	// A loaded box always ends inside the frame.
	a_box_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.action == ACT_ADD |->
			{1'b0, cmd.box.right} < wd && {1'b0, cmd.box.bottom} < ht)
		else $error("clipped box reaches past the frame");

	// A command word is only offered when the queue has room.
	a_push_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");

endmodule

// ===== rtl/core/bbo_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box overlay back end
// Keeps the box table, tests each pixel against every box border in
// parallel lanes and picks the colour of the last matching box.
// ----------------------------------------------------------------------------
module bbo_back #(
	parameter int MAX_BOXES = bbo_pkg::MAX_BOXES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  bbo_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output bbo_pkg::result_t res
);
	import bbo_pkg::*;

	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	box_t                 table_q [MAX_BOXES];
	logic [CNT_W-1:0]     count_q;
	logic                 s1_valid;
	logic [MAX_BOXES-1:0] hits_s1;
	pix_t                 pix_s1;

	logic                 stage_free;
	logic [MAX_BOXES-1:0] hits;
	logic [IDX_W-1:0]     sel;
	logic                 any;
	rgb_t                 colour;

	assign stage_free = !s1_valid || !res_full;
	assign cmd_pop    = !cmd_empty && stage_free;

	// Box table write and fill count.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.kind == CMD_ADD && count_q != CNT_W'(MAX_BOXES)) begin
			table_q[count_q[IDX_W-1:0]] <= cmd.box;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_pop) begin
			if (cmd.kind == CMD_CLEAR) begin
				count_q <= '0;
			end else if (cmd.kind == CMD_ADD && count_q != CNT_W'(MAX_BOXES)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// One border test per table entry.
	for (genvar k = 0; k < MAX_BOXES; k++) begin : g_lane
		box_t             b;
		logic             inside_box;
		logic [POS_W-1:0] dl, dr, dt, db;
		assign b          = table_q[k];
		assign inside_box = cmd.pix.col >= b.left && cmd.pix.col <= b.right &&
			cmd.pix.row >= b.top && cmd.pix.row <= b.bottom;
		assign dl = cmd.pix.col - b.left;
		assign dr = b.right - cmd.pix.col;
		assign dt = cmd.pix.row - b.top;
		assign db = b.bottom - cmd.pix.row;
		assign hits[k] = (count_q >= CNT_W'(k + 1)) && inside_box &&
			(dl < POS_W'(b.thick) || dr < POS_W'(b.thick) ||
			 dt < POS_W'(b.thick) || db < POS_W'(b.thick));
	end

	// Hit stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (stage_free) begin
			s1_valid <= cmd_pop && cmd.kind == CMD_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.kind == CMD_PIXEL) begin
			hits_s1 <= hits;
			pix_s1  <= cmd.pix;
		end
	end

	// The last loaded matching box wins.
	always_comb begin
		sel = '0;
		any = 1'b0;
		for (int k = 0; k < MAX_BOXES; k++) begin
			if (hits_s1[k]) begin
				sel = IDX_W'(k);
				any = 1'b1;
			end
		end
	end

	assign colour = palette_lookup(table_q[sel].colour);

	// Result word toward the output queue.
	always_comb begin
		res_push      = s1_valid && !res_full;
		res.out_c0    = any ? colour.c0 : pix_s1.c0;
		res.out_c1    = any ? colour.c1 : pix_s1.c1;
		res.out_c2    = any ? colour.c2 : pix_s1.c2;
		res.painted   = any;
		res.frame_end = pix_s1.frame_end;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BOXES))
		else $error("box count beyond table size");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && res_full |=> s1_valid && $stable(hits_s1) && $stable(pix_s1))
		else $error("hit stage changed while output stalled");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.kind == CMD_CLEAR |=> count_q == '0)
		else $error("box table not emptied by clear");

endmodule

// ===== rtl/core/bounding_box_overlay_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box overlay core
// Draws class-coloured rectangle outlines over a raster pixel stream.
// ----------------------------------------------------------------------------
// Words enter through push/full: action 0 clears the box table and restarts
// the raster position, action 1 loads one box (clipped to the frame when it
// is taken), action 2 passes one pixel in raster order. Only pixel words give
// a result word, read through empty/pop; it carries the pixel after overlay,
// a painted flag and a frame_end flag on the last pixel of the frame.
// The configuration channel (cfg_valid/cfg_ready, always ready) sets frame
// width, height and outline thickness; write it only while the core is idle.
// One word is taken per clock while full is low. A pixel's result passes
// through the command queue, then the hit stage register that holds the
// parallel border test over all table entries, then the output queue.
// When the receiver stops popping, the output queue and hit stage fill, the
// command queue backs up behind them and full rises; nothing is lost.
// Reset empties both queues and the box table and puts the raster position at
// the origin; the registers return to 640 by 480 with thickness 2.
// ----------------------------------------------------------------------------
module bounding_box_overlay_core #(
	parameter int MAX_BOXES = bbo_pkg::MAX_BOXES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  bbo_pkg::item_t            item,
	output logic                      full,
	output logic                      empty,
	input  logic                      pop,
	output bbo_pkg::result_t          result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [bbo_pkg::DIM_W-1:0] cfg_data
);
	import bbo_pkg::*;

	logic    cmd_push;
	cmd_t    cmd_wr;
	logic    cmd_full;
	cmd_t    cmd_rd;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_push;
	result_t res_wr;
	logic    res_full;

	bbo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_wr),
		.cmd_full  (cmd_full)
	);

	bbo_fifo #(
		.DEPTH (CMD_DEPTH),
		.T     (cmd_t)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	bbo_back #(
		.MAX_BOXES (MAX_BOXES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_wr)
	);

	bbo_fifo #(
		.DEPTH (RES_DEPTH),
		.T     (result_t)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
